// ----- rtl/core/rssm_pkg.sv -----
// ----------------------------------------------------------------------------
// rssm_pkg: shared types and constants of the rotate-shift sample mapper
// Holds the payload words, the register map and the stage-to-stage data.
// ----------------------------------------------------------------------------
package rssm_pkg;

  localparam int unsigned CoordW  = 12;  // coordinate fields
  localparam int unsigned DimW    = 13;  // frame size registers
  localparam int unsigned CfgW    = 16;  // configuration write data
  localparam int unsigned FracW   = 8;   // weight fields
  localparam int unsigned PosBits = 18;  // fraction bits of the rotated position
  localparam int unsigned CenW    = 18;  // centred position, 1/16 pixel
  localparam int unsigned ProdW   = 34;  // one rotation product
  localparam int unsigned PosW    = 36;  // rotated position, 2^-18 pixel
  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SHIFT_X      = 3'd0,
    CFG_SHIFT_Y      = 3'd1,
    CFG_COS_ANGLE    = 3'd2,
    CFG_SIN_ANGLE    = 3'd3,
    CFG_FRAME_WIDTH  = 3'd4,
    CFG_FRAME_HEIGHT = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [CoordW-1:0] out_col;
    logic [CoordW-1:0] out_row;
  } in_t;

  typedef struct packed {
    logic              near_valid;
    logic [CoordW-1:0] near_col;
    logic [CoordW-1:0] near_row;
    logic              interp_valid;
    logic [CoordW-1:0] low_col;
    logic [CoordW-1:0] low_row;
    logic [CoordW-1:0] high_col;
    logic [CoordW-1:0] high_row;
    logic [FracW-1:0]  frac_col;
    logic [FracW-1:0]  frac_row;
  } out_t;

  // Register contents as seen by the datapath; the frame sizes are already
  // saturated to the largest supported dimension.
  typedef struct packed {
    logic signed [CfgW-1:0] shift_x;
    logic signed [CfgW-1:0] shift_y;
    logic signed [CfgW-1:0] cos_angle;
    logic signed [CfgW-1:0] sin_angle;
    logic [DimW-1:0]        width;
    logic [DimW-1:0]        height;
  } cfg_t;

  typedef struct packed {
    logic signed [CenW-1:0] fx;
    logic signed [CenW-1:0] fy;
  } center_t;

  typedef struct packed {
    logic signed [ProdW-1:0] x_cos;
    logic signed [ProdW-1:0] y_sin;
    logic signed [ProdW-1:0] x_sin;
    logic signed [ProdW-1:0] y_cos;
  } prod_t;

  typedef struct packed {
    logic signed [PosW-1:0] rx;
    logic signed [PosW-1:0] ry;
  } pos_t;

endpackage

// ----- rtl/core/rssm_cfg.sv -----
// ----------------------------------------------------------------------------
// rssm_cfg: configuration register file
// Takes register writes and presents the settings with saturated frame sizes.
// ----------------------------------------------------------------------------
module rssm_cfg #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [rssm_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [rssm_pkg::CfgW-1:0]       cfg_data_i,
  output rssm_pkg::cfg_t                  cfg_o
);
  import rssm_pkg::*;

  logic signed [CfgW-1:0] shift_x_q, shift_y_q, cos_q, sin_q;
  logic [DimW-1:0]        width_q, height_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_x_q <= '0;
      shift_y_q <= '0;
      cos_q     <= 16'sd16384;
      sin_q     <= '0;
      width_q   <= 13'd1024;
      height_q  <= 13'd1024;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_SHIFT_X:      shift_x_q <= cfg_data_i;
        CFG_SHIFT_Y:      shift_y_q <= cfg_data_i;
        CFG_COS_ANGLE:    cos_q     <= cfg_data_i;
        CFG_SIN_ANGLE:    sin_q     <= cfg_data_i;
        CFG_FRAME_WIDTH:  width_q   <= cfg_data_i[DimW-1:0];
        CFG_FRAME_HEIGHT: height_q  <= cfg_data_i[DimW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_o.shift_x   = shift_x_q;
    cfg_o.shift_y   = shift_y_q;
    cfg_o.cos_angle = cos_q;
    cfg_o.sin_angle = sin_q;
    cfg_o.width     = (32'(width_q) > MAX_DIM) ? DimW'(MAX_DIM) : width_q;
    cfg_o.height    = (32'(height_q) > MAX_DIM) ? DimW'(MAX_DIM) : height_q;
  end

endmodule

// ----- rtl/core/rssm_center.sv -----
// ----------------------------------------------------------------------------
// rssm_center: input stage
// Registers the shifted position relative to the frame centre, in 1/16 pixel.
// ----------------------------------------------------------------------------
module rssm_center (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rssm_pkg::cfg_t       cfg_i,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  rssm_pkg::in_t        data_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output rssm_pkg::center_t    data_o
);
  import rssm_pkg::*;

  logic    valid_q, valid_d;
  center_t data_q, data_d;

  assign ready_o = !valid_q || ready_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  // fx = col*16 + shift_x - W*8, every term widened to the centred width.
  always_comb begin
    data_d.fx = $signed({2'b00, data_i.out_col, 4'b0000})
              + $signed({{2{cfg_i.shift_x[CfgW-1]}}, cfg_i.shift_x})
              - $signed({2'b00, cfg_i.width, 3'b000});
    data_d.fy = $signed({2'b00, data_i.out_row, 4'b0000})
              + $signed({{2{cfg_i.shift_y[CfgW-1]}}, cfg_i.shift_y})
              - $signed({2'b00, cfg_i.height, 3'b000});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ----- rtl/core/rssm_rotate.sv -----
// ----------------------------------------------------------------------------
// rssm_rotate: rotation stages
// Registers the four rotation products, then their sums plus the frame centre.
// ----------------------------------------------------------------------------
module rssm_rotate (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rssm_pkg::cfg_t       cfg_i,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  rssm_pkg::center_t    data_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output rssm_pkg::pos_t       data_o
);
  import rssm_pkg::*;

  logic  prod_valid_q, prod_valid_d, prod_ready;
  prod_t prod_q, prod_d;
  logic  pos_valid_q, pos_valid_d, pos_ready;
  pos_t  pos_q, pos_d;
  logic signed [PosW-1:0] half_w, half_h;

  assign pos_ready    = !pos_valid_q || ready_i;
  assign prod_ready   = !prod_valid_q || pos_ready;
  assign ready_o      = prod_ready;
  assign prod_valid_d = prod_ready ? valid_i : prod_valid_q;
  assign pos_valid_d  = pos_ready ? prod_valid_q : pos_valid_q;

  always_comb begin
    prod_d.x_cos = data_i.fx * cfg_i.cos_angle;
    prod_d.y_sin = data_i.fy * cfg_i.sin_angle;
    prod_d.x_sin = data_i.fx * cfg_i.sin_angle;
    prod_d.y_cos = data_i.fy * cfg_i.cos_angle;
  end

  // The frame centre W/2 in 2^-18 pixel is W * 2^17.
  assign half_w = $signed({6'b0, cfg_i.width, 17'b0});
  assign half_h = $signed({6'b0, cfg_i.height, 17'b0});

  always_comb begin
    pos_d.rx = $signed({{2{prod_q.x_cos[ProdW-1]}}, prod_q.x_cos})
             + $signed({{2{prod_q.y_sin[ProdW-1]}}, prod_q.y_sin})
             + half_w;
    pos_d.ry = $signed({{2{prod_q.y_cos[ProdW-1]}}, prod_q.y_cos})
             - $signed({{2{prod_q.x_sin[ProdW-1]}}, prod_q.x_sin})
             + half_h;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_valid_q <= 1'b0;
      pos_valid_q  <= 1'b0;
    end else begin
      prod_valid_q <= prod_valid_d;
      pos_valid_q  <= pos_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && prod_ready) begin
      prod_q <= prod_d;
    end
    if (prod_valid_q && pos_ready) begin
      pos_q <= pos_d;
    end
  end

  assign valid_o = pos_valid_q;
  assign data_o  = pos_q;

endmodule

// ----- rtl/core/rssm_resolve.sv -----
// ----------------------------------------------------------------------------
// rssm_resolve: result stage
// Turns the rotated position into nearest and interpolation fields and holds
// the result word until the receiver takes it.
// ----------------------------------------------------------------------------
module rssm_resolve #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rssm_pkg::cfg_t       cfg_i,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  rssm_pkg::pos_t       data_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output rssm_pkg::out_t       data_o
);
  import rssm_pkg::*;

  typedef struct packed {
    logic              near_ok;
    logic [CoordW-1:0] near;
    logic              interp_ok;
    logic [CoordW-1:0] low;
    logic [CoordW-1:0] high;
    logic [FracW-1:0]  frac;
  } axis_t;

  logic  valid_q, valid_d;
  out_t  data_q, data_d;
  axis_t ax_x, ax_y;

  // One axis: floor and truncation of the position, bounds and wrap-around.
  function automatic axis_t resolve_axis(logic signed [PosW-1:0] pos,
                                         logic [DimW-1:0] dim);
    axis_t                      res;
    logic [PosW-PosBits-1:0]    fl;
    logic [PosBits-1:0]         fr;
    logic [PosW-PosBits:0]      tx;
    logic [DimW-1:0]            low_inc;
    logic [PosBits-1:0]         fr_sh;
    fl      = pos[PosW-1:PosBits];
    fr      = pos[PosBits-1:0];
    // Truncation toward zero: a negative value with a fraction moves up by one.
    tx      = {fl[PosW-PosBits-1], fl}
            + {{(PosW-PosBits){1'b0}}, pos[PosW-1] && (|fr)};
    low_inc = fl[DimW-1:0] + DimW'(1);
    fr_sh   = fr >> (PosBits - FRAC_BITS);
    res.near_ok   = !tx[PosW-PosBits]
                 && (tx[PosW-PosBits-1:0] < {{(PosW-PosBits-DimW){1'b0}}, dim});
    res.near      = res.near_ok ? tx[CoordW-1:0] : '0;
    res.interp_ok = !pos[PosW-1]
                 && (fl < {{(PosW-PosBits-DimW){1'b0}}, dim});
    res.low       = res.interp_ok ? fl[CoordW-1:0] : '0;
    res.high      = (!res.interp_ok || low_inc == dim) ? '0 : low_inc[CoordW-1:0];
    res.frac      = res.interp_ok ? fr_sh[FracW-1:0] : '0;
    return res;
  endfunction

  assign ready_o = !valid_q || ready_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_comb begin
    ax_x = resolve_axis(data_i.rx, cfg_i.width);
    ax_y = resolve_axis(data_i.ry, cfg_i.height);
    data_d.near_valid   = ax_x.near_ok && ax_y.near_ok;
    data_d.near_col     = data_d.near_valid ? ax_x.near : '0;
    data_d.near_row     = data_d.near_valid ? ax_y.near : '0;
    data_d.interp_valid = ax_x.interp_ok && ax_y.interp_ok;
    data_d.low_col      = data_d.interp_valid ? ax_x.low : '0;
    data_d.low_row      = data_d.interp_valid ? ax_y.low : '0;
    data_d.high_col     = data_d.interp_valid ? ax_x.high : '0;
    data_d.high_row     = data_d.interp_valid ? ax_y.high : '0;
    data_d.frac_col     = data_d.interp_valid ? ax_x.frac : '0;
    data_d.frac_row     = data_d.interp_valid ? ax_y.frac : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ----- rtl/core/rotate_shift_sample_mapper.sv -----
// ----------------------------------------------------------------------------
// rotate_shift_sample_mapper: output pixel to source sample coordinate mapper
// Shifts and rotates one output pixel coordinate into the source frame and
// returns nearest and bilinear sampling coordinates with fractional weights.
// ----------------------------------------------------------------------------
// Usage:
// An input word carries one output pixel (out_col, out_row) on the in_*
// valid/ready channel. Each input word produces exactly one result word on the
// out_* valid/ready channel, in order. Settings are written through the cfg_*
// channel, which is always ready; register i of the map takes index i and
// writes to unused indexes are dropped. Settings must only change while no
// word is in flight.
// An accepted word is taken by the centring stage, the product register, the
// position register and the result register in that order, and shows on
// out_valid_o once the result register holds it.
// Throughput is one word per clock while the receiver keeps up, set by the
// four 18x16 multipliers working in parallel in a single stage. Each stage
// holds one word and advances as soon as the stage behind it has room, so a
// stalled receiver fills the pipeline from the back and in_ready_o only falls
// once all four stages hold a word. Reset empties the pipeline and loads the
// default settings: no shift, no rotation and a 1024 by 1024 frame.
// ----------------------------------------------------------------------------
module rotate_shift_sample_mapper #(
  parameter int unsigned MAX_DIM   = 4096,
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  rssm_pkg::in_t                 in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output rssm_pkg::out_t                out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rssm_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [rssm_pkg::CfgW-1:0]     cfg_data_i
);
  import rssm_pkg::*;

  cfg_t    cfg;
  logic    cen_valid, cen_ready;
  center_t cen_data;
  logic    pos_valid, pos_ready;
  pos_t    pos_data;

  // Register file; frame sizes come out already clamped to MAX_DIM.
  rssm_cfg #(
    .MAX_DIM (MAX_DIM)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Stage 1: shifted coordinate relative to the frame centre.
  rssm_center u_center (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .data_i  (in_data_i),
    .valid_o (cen_valid),
    .ready_i (cen_ready),
    .data_o  (cen_data)
  );

  // Stages 2 and 3: rotation products, then exact rotated position.
  rssm_rotate u_rotate (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (cen_valid),
    .ready_o (cen_ready),
    .data_i  (cen_data),
    .valid_o (pos_valid),
    .ready_i (pos_ready),
    .data_o  (pos_data)
  );

  // Stage 4: truncation, bounds checks, wrap and weights into the result word.
  rssm_resolve #(
    .FRAC_BITS (FRAC_BITS)
  ) u_resolve (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (pos_valid),
    .ready_o (pos_ready),
    .data_i  (pos_data),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_data_o)
  );

`ifndef SYNTHESIS
  // The input side only stalls when every stage, the result register too, is full.
  a_stall_needs_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled while the result register was free");

  // An exact position inside the frame also truncates to the same inside pixel.
  a_interp_implies_near : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.interp_valid) |->
      (out_data_o.near_valid && out_data_o.near_col == out_data_o.low_col &&
       out_data_o.near_row == out_data_o.low_row))
    else $error("interpolation result disagrees with nearest result");

  // The right neighbour is the next column or wraps to column zero.
  a_high_col_wrap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.interp_valid) |->
      (out_data_o.high_col == out_data_o.low_col + 12'd1 ||
       out_data_o.high_col == 12'd0))
    else $error("right neighbour column is neither next nor wrapped");

  // Out-of-frame nearest results carry zero coordinates.
  a_near_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.near_valid) |->
      (out_data_o.near_col == 12'd0 && out_data_o.near_row == 12'd0))
    else $error("invalid nearest result has nonzero coordinates");
`endif

endmodule

// ----- verif/rssm_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rssm_checker: scoreboard for the rotate-shift sample mapper
// Follows the register writes, maps every accepted pixel word to its expected
// sample word, and compares each result word field by field, in order.
// ----------------------------------------------------------------------------
module rssm_checker
  import rssm_pkg::*;
#(
  parameter int unsigned MAX_DIM   = 4096,
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  in_t                in_data_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  out_t               out_data_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  output int unsigned        mismatch_o,
  output int unsigned        backlog_o
);

  localparam longint MaxDim = longint'(MAX_DIM);
  localparam longint OnePix = longint'(1) << PosBits;
  localparam int unsigned ReportMax = 10;

  longint          shift_x_r = 0;
  longint          shift_y_r = 0;
  longint          cos_r     = 16384;
  longint          sin_r     = 0;
  logic [DimW-1:0] width_r   = 13'd1024;
  logic [DimW-1:0] height_r  = 13'd1024;

  out_t        mapped_q[$];
  out_t        want;
  int unsigned mismatch_cnt = 0;
  int unsigned result_cnt   = 0;

  // Exact fixed-point mapping of one output pixel into the source frame.
  function automatic out_t map_to_source(in_t px);
    longint w, h, fx, fy, rx, ry, tx, ty, lx, ly, hx, hy, wx, wy;
    out_t   r;
    w  = (longint'(width_r) > MaxDim) ? MaxDim : longint'(width_r);
    h  = (longint'(height_r) > MaxDim) ? MaxDim : longint'(height_r);
    fx = longint'(px.out_col) * 16 + shift_x_r - w * 8;
    fy = longint'(px.out_row) * 16 + shift_y_r - h * 8;
    rx = fx * cos_r + fy * sin_r + w * (OnePix / 2);
    ry = -fx * sin_r + fy * cos_r + h * (OnePix / 2);
    tx = rx / OnePix;
    ty = ry / OnePix;
    r  = '0;
    if (tx >= 0 && tx < w && ty >= 0 && ty < h) begin
      r.near_valid = 1'b1;
      r.near_col   = tx[CoordW-1:0];
      r.near_row   = ty[CoordW-1:0];
    end
    if (rx >= 0 && rx < w * OnePix && ry >= 0 && ry < h * OnePix) begin
      lx = rx >>> PosBits;
      ly = ry >>> PosBits;
      hx = (lx + 1) % w;
      hy = (ly + 1) % h;
      wx = (rx & (OnePix - 1)) >>> (PosBits - FRAC_BITS);
      wy = (ry & (OnePix - 1)) >>> (PosBits - FRAC_BITS);
      r.interp_valid = 1'b1;
      r.low_col      = lx[CoordW-1:0];
      r.low_row      = ly[CoordW-1:0];
      r.high_col     = hx[CoordW-1:0];
      r.high_row     = hy[CoordW-1:0];
      r.frac_col     = wx[FracW-1:0];
      r.frac_row     = wy[FracW-1:0];
    end
    return r;
  endfunction

  task automatic check_field(string name, longint unsigned exp_v, longint unsigned act_v);
    if (exp_v != act_v) begin
      mismatch_cnt++;
      if (mismatch_cnt <= ReportMax)
        $display("[%0t] result %0d: %s expected 0x%0h, got 0x%0h",
                 $time, result_cnt, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_x_r = 0;
      shift_y_r = 0;
      cos_r     = 16384;
      sin_r     = 0;
      width_r   = 13'd1024;
      height_r  = 13'd1024;
      mapped_q.delete();
      backlog_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_SHIFT_X:      shift_x_r = longint'($signed(cfg_data_i));
          CFG_SHIFT_Y:      shift_y_r = longint'($signed(cfg_data_i));
          CFG_COS_ANGLE:    cos_r     = longint'($signed(cfg_data_i));
          CFG_SIN_ANGLE:    sin_r     = longint'($signed(cfg_data_i));
          CFG_FRAME_WIDTH:  width_r   = cfg_data_i[DimW-1:0];
          CFG_FRAME_HEIGHT: height_r  = cfg_data_i[DimW-1:0];
          default: ;
        endcase
      end

      if (out_valid_i && out_ready_i) begin
        if (mapped_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= ReportMax)
            $display("[%0t] result word 0x%0h arrived with none expected",
                     $time, out_data_i);
        end else begin
          want = mapped_q.pop_front();
          check_field("near_valid",   want.near_valid,   out_data_i.near_valid);
          check_field("near_col",     want.near_col,     out_data_i.near_col);
          check_field("near_row",     want.near_row,     out_data_i.near_row);
          check_field("interp_valid", want.interp_valid, out_data_i.interp_valid);
          check_field("low_col",      want.low_col,      out_data_i.low_col);
          check_field("low_row",      want.low_row,      out_data_i.low_row);
          check_field("high_col",     want.high_col,     out_data_i.high_col);
          check_field("high_row",     want.high_row,     out_data_i.high_row);
          check_field("frac_col",     want.frac_col,     out_data_i.frac_col);
          check_field("frac_row",     want.frac_row,     out_data_i.frac_row);
        end
        result_cnt++;
      end

      if (in_valid_i && in_ready_i) mapped_q.push_back(map_to_source(in_data_i));

      backlog_o <= mapped_q.size();
    end
    mismatch_o <= mismatch_cnt;
  end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench of the rotate-shift sample mapper
// Drives pixel words and register writes into the mapper, lets a separate
// scoreboard predict and compare every result word, and gives the verdict.
// ----------------------------------------------------------------------------
module tb;
  import rssm_pkg::*;

  localparam int unsigned MaxDim      = 4096;
  localparam int unsigned FracBits    = 8;
  localparam int unsigned ClkPeriod   = 10;
  localparam int unsigned ResetCycles = 10;
  // Roughly ten times the slowest legal run: every word behind the longest
  // sender gap and the longest receiver stall, plus the register phases.
  localparam int unsigned CycleLimit  = 400000;
  // Four pipeline stages; a few spare cycles catch any stray result word.
  localparam int unsigned DrainCycles = 12;
  localparam int unsigned PhaseWords  = 75;
  localparam int unsigned PhaseCount  = 8;
  localparam real         Pi          = 3.141592653589793;

  // Register indexes outside the map; the mapper must drop writes to them.
  localparam logic [CfgIdxW-1:0] CfgSpareLo = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgSpareHi = 3'd7;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid    = 1'b0;
  logic               in_ready;
  in_t                in_data     = '0;
  logic               out_valid;
  logic               out_ready   = 1'b0;
  out_t               out_data;
  logic               cfg_valid   = 1'b0;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index   = '0;
  logic [CfgW-1:0]    cfg_data    = '0;

  int unsigned mismatches;
  int unsigned backlog;
  int unsigned cycle_cnt = 0;

  // Sender burst shape and receiver stall pattern; both change per phase.
  int unsigned burst_left = 0;
  int unsigned burst_max  = 4;
  int unsigned gap_max    = 3;
  int unsigned stall_pct  = 30;
  int unsigned stall_max  = 4;
  int unsigned stall_left = 0;

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  rotate_shift_sample_mapper #(
    .MAX_DIM  (MaxDim),
    .FRAC_BITS(FracBits)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  rssm_checker #(
    .MAX_DIM  (MaxDim),
    .FRAC_BITS(FracBits)
  ) u_rssm_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_i (in_ready),
    .in_data_i  (in_data),
    .out_valid_i(out_valid),
    .out_ready_i(out_ready),
    .out_data_i (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data),
    .mismatch_o (mismatches),
    .backlog_o  (backlog)
  );

  // The receiver either takes a word or sits out a stall of random length.
  // A stall chance of zero gives stretches where every result drains at once.
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else if ($urandom_range(99) < stall_pct) begin
      out_ready  <= 1'b0;
      stall_left = $urandom_range(stall_max);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("rotate_shift_sample_mapper test failed");
      $finish;
    end
  end

  // Frame size word for a register write; the bits above the 13-bit size are
  // junk that the mapper has to ignore.
  function automatic logic [CfgW-1:0] dim_word(int unsigned dim);
    logic [CfgW-DimW-1:0] junk;
    junk = ($urandom_range(3) == 0) ? '0 : (CfgW-DimW)'($urandom());
    return {junk, dim[DimW-1:0]};
  endfunction

  // Offer one pixel word and hold it until the mapper takes it. Unless gap_max
  // is zero, a new burst starts after a gap with valid low, so idle cycles
  // land at every stage of the pipeline.
  task automatic send_pixel(logic [CoordW-1:0] col, logic [CoordW-1:0] row);
    in_t px;
    px.out_col = col;
    px.out_row = row;
    if (burst_left == 0) begin
      if (gap_max != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(gap_max, 1)) @(posedge clk_i);
      end
      burst_left = $urandom_range(burst_max, 1);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= px;
    do @(posedge clk_i); while (!in_ready);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
  endtask

  // Settings may only change with the pipeline empty, so the input side goes
  // quiet and every outstanding result word is collected first. Each call
  // writes all six registers, optionally followed by writes to the spare
  // indexes.
  task automatic load_setting(logic [CfgW-1:0] sx, logic [CfgW-1:0] sy,
                              logic [CfgW-1:0] cs, logic [CfgW-1:0] sn,
                              logic [CfgW-1:0] wd, logic [CfgW-1:0] hd, bit spare);
    in_valid <= 1'b0;
    do @(posedge clk_i); while (backlog != 0);
    write_reg(CFG_SHIFT_X, sx);
    write_reg(CFG_SHIFT_Y, sy);
    write_reg(CFG_COS_ANGLE, cs);
    write_reg(CFG_SIN_ANGLE, sn);
    write_reg(CFG_FRAME_WIDTH, wd);
    write_reg(CFG_FRAME_HEIGHT, hd);
    if (spare) begin
      write_reg(CfgSpareLo, CfgW'($urandom()));
      write_reg(CfgSpareHi, CfgW'($urandom()));
    end
    cfg_valid  <= 1'b0;
    burst_left = 0;
  endtask

  // Frame sizes lean toward small frames and the edges of the range: the
  // smallest frame, the largest, an empty one and sizes that saturate.
  function automatic int unsigned pick_dim();
    case ($urandom_range(9))
      0:       return 2;
      1:       return MaxDim;
      2:       return 0;
      3:       return $urandom_range(8191, MaxDim + 1);
      4, 5:    return $urandom_range(64, 2);
      default: return $urandom_range(MaxDim, 2);
    endcase
  endfunction

  // One random phase: a fresh setting, a fresh traffic shape, then a run of
  // pixel words. Most settings are true rotations with small shifts, so most
  // words land inside the frame; the rest use raw register values. Most
  // pixels come from the output frame itself, some from anywhere.
  task automatic run_random_phase(int unsigned n_words);
    int unsigned     w, h, col_lim, row_lim;
    real             ang;
    logic [CfgW-1:0] sx, sy, cs, sn;
    logic [CoordW-1:0] col, row;
    w = pick_dim();
    h = pick_dim();
    if ($urandom_range(3) != 0) begin
      ang = real'($urandom_range(3599)) * Pi / 1800.0;
      cs  = CfgW'($rtoi(16384.0 * $cos(ang)));
      sn  = CfgW'($rtoi(16384.0 * $sin(ang)));
    end else begin
      cs = CfgW'($urandom());
      sn = CfgW'($urandom());
    end
    if ($urandom_range(9) < 7) begin
      sx = CfgW'(int'($urandom_range(256)) - 128);
      sy = CfgW'(int'($urandom_range(256)) - 128);
    end else begin
      sx = CfgW'($urandom());
      sy = CfgW'($urandom());
    end
    load_setting(sx, sy, cs, sn, dim_word(w), dim_word(h), $urandom_range(1));

    case ($urandom_range(3))
      0: begin gap_max = 0;  burst_max = 1;  stall_pct = 0;  stall_max = 0;  end
      1: begin gap_max = 3;  burst_max = 8;  stall_pct = 20; stall_max = 3;  end
      2: begin gap_max = 12; burst_max = 3;  stall_pct = 50; stall_max = 12; end
      default: begin gap_max = 1; burst_max = 30; stall_pct = 10; stall_max = 6; end
    endcase

    col_lim = (w == 0 || w > MaxDim) ? MaxDim : w;
    row_lim = (h == 0 || h > MaxDim) ? MaxDim : h;
    repeat (n_words) begin
      if ($urandom_range(4) == 0) begin
        col = CoordW'($urandom());
        row = CoordW'($urandom());
      end else begin
        col = CoordW'($urandom_range(col_lim - 1));
        row = CoordW'($urandom_range(row_lim - 1));
      end
      send_pixel(col, row);
    end
  endtask

  initial begin
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset setting: identity mapping on a 1024 by 1024 frame. Corners, the
    // frame edge and alternating bit patterns in both coordinates.
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd1023, 12'd1023);
    send_pixel(12'd1024, 12'd1023);
    send_pixel(12'hAAA, 12'h555);
    send_pixel(12'h555, 12'hAAA);

    // Shifts of -1/2 pixel in x and -3/2 pixel in y: positions just left of zero
    // truncate to a valid nearest sample while the exact position is out of frame.
    load_setting(-16'sd8, -16'sd24, 16'sd16384, 16'sd0,
                 dim_word(1024), dim_word(1024), 1'b0);
    send_pixel(12'd0, 12'd1);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd1023, 12'd1023);

    // Positive half-pixel shifts: the last column and row wrap their upper
    // neighbours to zero.
    load_setting(16'sd8, 16'sd8, 16'sd16384, 16'sd0,
                 dim_word(1024), dim_word(1024), 1'b0);
    send_pixel(12'd1023, 12'd1023);
    send_pixel(12'd0, 12'd0);

    // Quarter turn on the smallest frame.
    load_setting(16'sd0, 16'sd0, 16'sd0, 16'sd16384, dim_word(2), dim_word(2), 1'b0);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd1, 12'd1);
    send_pixel(12'd1, 12'd0);

    // Negative extremes of cosine and sine; the frame sizes saturate, and the
    // spare indexes are written too.
    load_setting(16'sd0, 16'sd0, -16'sd16384, -16'sd16384,
                 dim_word(8191), dim_word(MaxDim + 1), 1'b1);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd2048, 12'd2048);

    // Raw register extremes with an empty frame in one direction each.
    load_setting(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, dim_word(0), dim_word(MaxDim), 1'b0);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    load_setting(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, dim_word(MaxDim), dim_word(0), 1'b0);
    send_pixel(12'd0, 12'd4095);
    send_pixel(12'd4095, 12'd0);

    repeat (PhaseCount) run_random_phase(PhaseWords);

    // Collect every outstanding word, then watch a little longer for strays.
    in_valid <= 1'b0;
    do @(posedge clk_i); while (backlog != 0);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatches == 0 && backlog == 0) begin
      $display("rotate_shift_sample_mapper test passed");
    end else begin
      $display("rotate_shift_sample_mapper test failed");
    end
    $finish;
  end

endmodule
